// ===== hdl/normalized_cross_product_macros.svh =====
// ---------------------------------------------------------------------------
// Normalized cross product assertion macros
// Concurrent assertion wrappers, compiled out under synthesis.
// ---------------------------------------------------------------------------
`ifndef NORMALIZED_CROSS_PRODUCT_MACROS_SVH
`define NORMALIZED_CROSS_PRODUCT_MACROS_SVH
`ifndef SYNTHESIS
`define NCP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("ncp check failed");
`define NCP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error("ncp implication failed");
`else
`define NCP_ASSERT(label, clk, rst, prop)
`define NCP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/ncp_pkg.sv =====
// ---------------------------------------------------------------------------
// Normalized cross product package
// Widths, latencies and shared types of the unit-normal pipeline.
// ---------------------------------------------------------------------------
package ncp_pkg;

  localparam int IN_W      = 16;
  localparam int OUT_FRAC  = 14;
  localparam int OUT_W     = 16;
  localparam int PROD_W    = 2 * IN_W;
  localparam int MAG_W     = 2 * IN_W - 1;
  localparam int SHIFT_W   = $clog2(MAG_W);
  localparam int SUM_W     = 2 * MAG_W + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int Q_W       = OUT_FRAC + 2;
  localparam int DREM_W    = ROOT_W + 1;
  localparam int FRONT_LAT = 6;
  localparam int SQRT_LAT  = ROOT_W;
  localparam int DIV_LAT   = Q_W;
  localparam int TOTAL_LAT = FRONT_LAT + SQRT_LAT + DIV_LAT + 1;

  localparam logic [OUT_W-1:0] ONE = OUT_W'(1) << OUT_FRAC;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  par;
  } vec_t;

endpackage

// ===== hdl/ncp_front.sv =====
// ---------------------------------------------------------------------------
// Normalized cross product front end
// Products, cross magnitudes, block normalization and sum of squares.
// ---------------------------------------------------------------------------
module ncp_front (
  input  logic                              clk,
  input  logic signed [ncp_pkg::IN_W-1:0]   a_x,
  input  logic signed [ncp_pkg::IN_W-1:0]   a_y,
  input  logic signed [ncp_pkg::IN_W-1:0]   a_z,
  input  logic signed [ncp_pkg::IN_W-1:0]   b_x,
  input  logic signed [ncp_pkg::IN_W-1:0]   b_y,
  input  logic signed [ncp_pkg::IN_W-1:0]   b_z,
  output ncp_pkg::vec_t                     vec,
  output logic [ncp_pkg::SUM_W-1:0]         sum
);

  logic signed [ncp_pkg::PROD_W-1:0] prod [6];
  ncp_pkg::vec_t v2, v3, v4, v5, v6;
  logic [ncp_pkg::SHIFT_W-1:0] sh, sh_next;
  logic [2*ncp_pkg::MAG_W-1:0] sq [3];
  logic signed [ncp_pkg::PROD_W:0] diff [3];
  logic [ncp_pkg::MAG_W-1:0] orv;

  always_ff @(posedge clk) begin
    prod[0] <= a_y * b_z;
    prod[1] <= b_y * a_z;
    prod[2] <= a_z * b_x;
    prod[3] <= b_z * a_x;
    prod[4] <= a_x * b_y;
    prod[5] <= b_x * a_y;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = {prod[2*k][ncp_pkg::PROD_W-1], prod[2*k]}
              - {prod[2*k+1][ncp_pkg::PROD_W-1], prod[2*k+1]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      v2.neg[k] <= diff[k][ncp_pkg::PROD_W];
      v2.mag[k] <= diff[k][ncp_pkg::PROD_W] ? ncp_pkg::MAG_W'(-diff[k])
                                            : ncp_pkg::MAG_W'(diff[k]);
    end
    v2.par <= (diff[0] == '0) && (diff[1] == '0) && (diff[2] == '0);
  end

  // The top set bit of the OR is the top set bit of the largest magnitude
  assign orv = v2.mag[0] | v2.mag[1] | v2.mag[2];

  always_comb begin
    sh_next = '0;
    for (int i = 0; i < ncp_pkg::MAG_W; i++) begin
      if (orv[i]) begin
        sh_next = ncp_pkg::SHIFT_W'(ncp_pkg::MAG_W - 1 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    v3 <= v2;
    sh <= sh_next;
    v4.neg <= v3.neg;
    v4.par <= v3.par;
    for (int k = 0; k < 3; k++) begin
      v4.mag[k] <= v3.mag[k] << sh;
    end
    v5 <= v4;
    for (int k = 0; k < 3; k++) begin
      sq[k] <= v4.mag[k] * v4.mag[k];
    end
    v6 <= v5;
    sum <= ncp_pkg::SUM_W'(sq[0]) + ncp_pkg::SUM_W'(sq[1]) + ncp_pkg::SUM_W'(sq[2]);
  end

  assign vec = v6;

endmodule

// ===== hdl/ncp_sqrt.sv =====
// ---------------------------------------------------------------------------
// Normalized cross product square root
// Pipelined integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
module ncp_sqrt (
  input  logic                        clk,
  input  logic [ncp_pkg::SUM_W-1:0]   sum,
  output logic [ncp_pkg::ROOT_W-1:0]  root
);

  logic [ncp_pkg::REM_W-1:0]  rem_r  [ncp_pkg::ROOT_W];
  logic [ncp_pkg::ROOT_W-1:0] root_r [ncp_pkg::ROOT_W];
  logic [ncp_pkg::SUM_W-1:0]  sv_r   [ncp_pkg::ROOT_W];

  for (genvar i = 0; i < ncp_pkg::ROOT_W; i++) begin : g_st
    logic [ncp_pkg::REM_W-1:0]  rem_in, rem_sh, trial;
    logic [ncp_pkg::ROOT_W-1:0] root_in;
    logic [ncp_pkg::SUM_W-1:0]  sv_in;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign sv_in   = sum;
    end else begin : g_rest
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign sv_in   = sv_r[i-1];
    end

    // Bring down the next two radicand bits
    assign rem_sh = {rem_in[ncp_pkg::REM_W-3:0], sv_in[ncp_pkg::SUM_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      sv_r[i] <= sv_in << 2;
      if (rem_sh >= trial) begin
        rem_r[i]  <= rem_sh - trial;
        root_r[i] <= {root_in[ncp_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r[i]  <= rem_sh;
        root_r[i] <= {root_in[ncp_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root = root_r[ncp_pkg::ROOT_W-1];

endmodule

// ===== hdl/ncp_div.sv =====
// ---------------------------------------------------------------------------
// Normalized cross product divider
// Pipelined restoring division of a scaled magnitude by the vector length.
// ---------------------------------------------------------------------------
module ncp_div (
  input  logic                        clk,
  input  logic [ncp_pkg::MAG_W-1:0]   mag,
  input  logic [ncp_pkg::ROOT_W-1:0]  len,
  output logic [ncp_pkg::Q_W-1:0]     quo
);

  logic [ncp_pkg::DREM_W-1:0] rem_r [ncp_pkg::Q_W];
  logic [ncp_pkg::ROOT_W-1:0] len_r [ncp_pkg::Q_W];
  logic [ncp_pkg::Q_W-1:0]    q_r   [ncp_pkg::Q_W];

  for (genvar i = 0; i < ncp_pkg::Q_W; i++) begin : g_st
    logic [ncp_pkg::DREM_W-1:0] rem_in, rem_sh, dvs;
    logic [ncp_pkg::ROOT_W-1:0] len_in;
    logic [ncp_pkg::Q_W-1:0]    q_in;
    logic                       nbit;

    // Dividend is mag << (OUT_FRAC+1): only the top quotient step sees mag[0]
    if (i == 0) begin : g_first
      assign rem_in = ncp_pkg::DREM_W'(mag[ncp_pkg::MAG_W-1:1]);
      assign len_in = len;
      assign q_in   = '0;
      assign nbit   = mag[0];
    end else begin : g_rest
      assign rem_in = rem_r[i-1];
      assign len_in = len_r[i-1];
      assign q_in   = q_r[i-1];
      assign nbit   = 1'b0;
    end

    assign rem_sh = {rem_in[ncp_pkg::DREM_W-2:0], nbit};
    assign dvs    = {1'b0, len_in};

    always_ff @(posedge clk) begin
      len_r[i] <= len_in;
      if (rem_sh >= dvs) begin
        rem_r[i] <= rem_sh - dvs;
        q_r[i]   <= {q_in[ncp_pkg::Q_W-2:0], 1'b1};
      end else begin
        rem_r[i] <= rem_sh;
        q_r[i]   <= {q_in[ncp_pkg::Q_W-2:0], 1'b0};
      end
    end
  end

  assign quo = q_r[ncp_pkg::Q_W-1];

endmodule

// ===== hdl/normalized_cross_product.sv =====
// ---------------------------------------------------------------------------
// Normalized cross product
// Unit normal of two Q4.11 3-vectors, returned in Q1.14.
// ---------------------------------------------------------------------------
// Input channel: drive the six components with start high; a transaction is
// taken at every rising edge with start high, busy is always low.
// Output channel: done pulses for one cycle with unit_x, unit_y, unit_z and
// was_parallel valid in that cycle; there is no back pressure.
// The result passes the front end, root pipeline, dividers and output register;
// done rises at the same edge that registers it.
// Throughput: one transaction per cycle. The length sits behind a 32-stage
// root pipeline and the three components behind 16-stage dividers, one bit
// per stage each; products, normalization and squares take six stages.
// A zero cross product returns the unit x axis with was_parallel set.
// Reset clears the valid bits of every stage; transactions in flight are
// dropped, and no done pulse follows until new input arrives.
// ---------------------------------------------------------------------------
`include "normalized_cross_product_macros.svh"

module normalized_cross_product (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ncp_pkg::IN_W-1:0]     a_x,
  input  logic signed [ncp_pkg::IN_W-1:0]     a_y,
  input  logic signed [ncp_pkg::IN_W-1:0]     a_z,
  input  logic signed [ncp_pkg::IN_W-1:0]     b_x,
  input  logic signed [ncp_pkg::IN_W-1:0]     b_y,
  input  logic signed [ncp_pkg::IN_W-1:0]     b_z,
  output logic                                done,
  output logic signed [ncp_pkg::OUT_W-1:0]    unit_x,
  output logic signed [ncp_pkg::OUT_W-1:0]    unit_y,
  output logic signed [ncp_pkg::OUT_W-1:0]    unit_z,
  output logic                                was_parallel
);

  localparam int SIDE_LAT = ncp_pkg::SQRT_LAT + ncp_pkg::DIV_LAT;
  localparam int DONE_DLY = ncp_pkg::TOTAL_LAT;
  localparam logic signed [ncp_pkg::OUT_W-1:0] ONE_S = ncp_pkg::ONE;

  logic [ncp_pkg::TOTAL_LAT-1:0] vld;
  ncp_pkg::vec_t vec;
  logic [ncp_pkg::SUM_W-1:0] sum;
  logic [ncp_pkg::ROOT_W-1:0] len;
  logic [2:0][ncp_pkg::MAG_W-1:0] mag_dly [ncp_pkg::SQRT_LAT];
  logic [3:0] side_dly [SIDE_LAT];
  logic [ncp_pkg::Q_W-1:0] quo [3];
  logic [ncp_pkg::OUT_W-1:0] comp_next [3];
  logic [ncp_pkg::Q_W-1:0] rnd;
  logic [ncp_pkg::OUT_W-1:0] mag_n;
  logic [3:0] side_out;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ncp_pkg::TOTAL_LAT-2:0], start & ~busy};
    end
  end

  ncp_front u_front (
    .clk (clk),
    .a_x (a_x),
    .a_y (a_y),
    .a_z (a_z),
    .b_x (b_x),
    .b_y (b_y),
    .b_z (b_z),
    .vec (vec),
    .sum (sum)
  );

  ncp_sqrt u_sqrt (
    .clk  (clk),
    .sum  (sum),
    .root (len)
  );

  // Hold magnitudes until the length comes out; signs and flag until the end
  always_ff @(posedge clk) begin
    mag_dly[0]  <= vec.mag;
    side_dly[0] <= {vec.neg, vec.par};
    for (int i = 1; i < ncp_pkg::SQRT_LAT; i++) begin
      mag_dly[i] <= mag_dly[i-1];
    end
    for (int i = 1; i < SIDE_LAT; i++) begin
      side_dly[i] <= side_dly[i-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    ncp_div u_div (
      .clk (clk),
      .mag (mag_dly[ncp_pkg::SQRT_LAT-1][k]),
      .len (len),
      .quo (quo[k])
    );
  end

  assign side_out = side_dly[SIDE_LAT-1];

  // Round half up, clamp to one, then apply the sign
  always_comb begin
    rnd   = '0;
    mag_n = '0;
    for (int k = 0; k < 3; k++) begin
      rnd   = (quo[k] + ncp_pkg::Q_W'(1)) >> 1;
      mag_n = ncp_pkg::OUT_W'(rnd);
      if (mag_n > ncp_pkg::ONE) begin
        mag_n = ncp_pkg::ONE;
      end
      comp_next[k] = (side_out[k+1] && mag_n != '0) ? -mag_n : mag_n;
    end
  end

  always_ff @(posedge clk) begin
    if (side_out[0]) begin
      unit_x <= ONE_S;
      unit_y <= '0;
      unit_z <= '0;
    end else begin
      unit_x <= comp_next[0];
      unit_y <= comp_next[1];
      unit_z <= comp_next[2];
    end
    was_parallel <= side_out[0];
  end

  assign done = vld[ncp_pkg::TOTAL_LAT-1];

  `NCP_ASSERT_IMPLY(a_latency, clk, rst, start && !busy, ##DONE_DLY done)
  `NCP_ASSERT_IMPLY(a_parallel_axis, clk, rst, done && was_parallel, (unit_x == ONE_S && unit_y == 0 && unit_z == 0))
  `NCP_ASSERT_IMPLY(a_unit_range, clk, rst, done, (unit_x <= ONE_S && unit_x >= -ONE_S && unit_y <= ONE_S && unit_y >= -ONE_S && unit_z <= ONE_S && unit_z >= -ONE_S))

endmodule

// ===== sim/ncp_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Normalized cross product checker
// Watches the input and result channels, predicts each unit normal from the
// accepted vector pair and compares it field by field with the block output.
// ---------------------------------------------------------------------------
module ncp_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic signed [ncp_pkg::IN_W-1:0]  a_x,
  input  logic signed [ncp_pkg::IN_W-1:0]  a_y,
  input  logic signed [ncp_pkg::IN_W-1:0]  a_z,
  input  logic signed [ncp_pkg::IN_W-1:0]  b_x,
  input  logic signed [ncp_pkg::IN_W-1:0]  b_y,
  input  logic signed [ncp_pkg::IN_W-1:0]  b_z,
  input  logic                             done,
  input  logic signed [ncp_pkg::OUT_W-1:0] unit_x,
  input  logic signed [ncp_pkg::OUT_W-1:0] unit_y,
  input  logic signed [ncp_pkg::OUT_W-1:0] unit_z,
  input  logic                             was_parallel,
  output int                               errors,
  output int                               pending,
  output int                               normals_seen,
  output int                               parallel_seen
);

  typedef struct {
    logic [ncp_pkg::OUT_W-1:0] ux;
    logic [ncp_pkg::OUT_W-1:0] uy;
    logic [ncp_pkg::OUT_W-1:0] uz;
    logic                      par;
  } normal_t;

  normal_t expected_normals[$];

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic normal_t unit_normal(longint ax, longint ay, longint az,
                                          longint bx, longint by, longint bz);
    normal_t         res;
    longint          c[3];
    longint unsigned m[3];
    logic            ng[3];
    longint unsigned top, len, n, one;
    one = 64'd1 << ncp_pkg::OUT_FRAC;
    c[0] = ay * bz - by * az;
    c[1] = az * bx - bz * ax;
    c[2] = ax * by - bx * ay;
    for (int i = 0; i < 3; i++) begin
      ng[i] = c[i] < 0;
      m[i] = ng[i] ? -c[i] : c[i];
    end
    res.par = 1'b0;
    if (m[0] == 0 && m[1] == 0 && m[2] == 0) begin
      res.ux = ncp_pkg::ONE;
      res.uy = '0;
      res.uz = '0;
      res.par = 1'b1;
      return res;
    end
    top = m[0];
    if (m[1] > top) top = m[1];
    if (m[2] > top) top = m[2];
    while (top < (64'd1 << 30)) begin
      top <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    while (top >= (64'd1 << 31)) begin
      top >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      n = ((m[i] << (ncp_pkg::OUT_FRAC + 1)) / len + 1) >> 1;
      if (n > one) n = one;
      if (ng[i]) n = -n;
      if (i == 0) res.ux = n[ncp_pkg::OUT_W-1:0];
      else if (i == 1) res.uy = n[ncp_pkg::OUT_W-1:0];
      else res.uz = n[ncp_pkg::OUT_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    normal_t want;
    int      bad;
    bad = 0;
    if (rst) begin
      errors <= 0;
      pending <= 0;
      normals_seen <= 0;
      parallel_seen <= 0;
      expected_normals.delete();
    end else begin
      if (done) begin
        if (expected_normals.size() == 0) begin
          $error("unexpected result transaction");
          bad++;
        end else begin
          want = expected_normals.pop_front();
          normals_seen <= normals_seen + 1;
          if (want.par) parallel_seen <= parallel_seen + 1;
          if (unit_x !== want.ux) begin
            $error("unit_x: expected %0d, got %0d", $signed(want.ux), unit_x);
            bad++;
          end
          if (unit_y !== want.uy) begin
            $error("unit_y: expected %0d, got %0d", $signed(want.uy), unit_y);
            bad++;
          end
          if (unit_z !== want.uz) begin
            $error("unit_z: expected %0d, got %0d", $signed(want.uz), unit_z);
            bad++;
          end
          if (was_parallel !== want.par) begin
            $error("was_parallel: expected %0b, got %0b", want.par, was_parallel);
            bad++;
          end
        end
      end
      if (start && !busy)
        expected_normals.push_back(unit_normal(a_x, a_y, a_z, b_x, b_y, b_z));
      errors <= errors + bad;
      pending <= expected_normals.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Normalized cross product testbench
// Drives directed and random vector pairs at varying rates and lets the
// checker compare every unit normal against its own prediction.
// ---------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_PAIRS = 1800;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [ncp_pkg::IN_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
  logic done;
  logic signed [ncp_pkg::OUT_W-1:0] unit_x, unit_y, unit_z;
  logic was_parallel;
  int errors, pending, normals_seen, parallel_seen;
  int cycles;
  int gap_pct;

  normalized_cross_product dut (.*);

  ncp_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [ncp_pkg::IN_W-1:0] pick_component();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(signed'($urandom_range(0, 8)) - 4);
      3: return 16'(1) << $urandom_range(0, 15);
      default: return ncp_pkg::IN_W'($urandom());
    endcase
  endfunction

  // Hold one pair on the inputs until it is taken; idle first at random.
  task automatic send_pair(input logic [ncp_pkg::IN_W-1:0] ax, ay, az, bx, by, bz);
    while ($urandom_range(1, 100) <= gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    a_x <= ax; a_y <= ay; a_z <= az;
    b_x <= bx; b_y <= by; b_z <= bz;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random();
    logic [ncp_pkg::IN_W-1:0] v[6];
    int k;
    for (int i = 0; i < 6; i++) v[i] = pick_component();
    case ($urandom_range(0, 9))
      0: begin  // scaled copy: parallel vectors
        k = $urandom_range(0, 4) - 2;
        v[3] = ncp_pkg::IN_W'(v[0] * k);
        v[4] = ncp_pkg::IN_W'(v[1] * k);
        v[5] = ncp_pkg::IN_W'(v[2] * k);
      end
      1: begin  // one vector zero
        v[3] = '0; v[4] = '0; v[5] = '0;
      end
      2: begin  // small vectors, tiny cross products
        for (int i = 0; i < 6; i++) v[i] = 16'(signed'($urandom_range(0, 6)) - 3);
      end
      default: ;
    endcase
    send_pair(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    {a_x, a_y, a_z, b_x, b_y, b_z} = '0;
    gap_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, axes, parallel and zero vectors.
    send_pair(16'h0800, 0, 0, 0, 16'h0800, 0);
    send_pair(0, 16'h0800, 0, 16'h0800, 0, 0);
    send_pair(0, 0, 16'h0800, 16'h0800, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(16'h0800, 16'h0800, 16'h0800, 0, 0, 0);
    send_pair(16'h1000, 16'h2000, 16'h3000, 16'h2000, 16'h4000, 16'h6000);
    send_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pair(16'h8000, 0, 0, 0, 16'h8000, 0);
    send_pair(16'h7fff, 0, 0, 0, 16'h8000, 0);
    send_pair(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_pair(16'h8000, 16'h7fff, 0, 16'h7fff, 16'h8000, 16'h7fff);
    send_pair(1, 0, 0, 0, 1, 0);
    send_pair(16'hffff, 0, 0, 0, 1, 0);
    send_pair(1, 1, 1, 1, 1, 16'hffff);
    send_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_pair(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    send_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7ffe);
    send_pair(1, 2, 3, 4, 5, 6);

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i < RANDOM_PAIRS / 3) gap_pct = 34;
      else if (i < 2 * RANDOM_PAIRS / 3) gap_pct = 45;
      else gap_pct = 0;
      send_random();
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (ncp_pkg::TOTAL_LAT + 10) @(posedge clk);

    $display("checked %0d unit normals, %0d of them from parallel or zero pairs",
             normals_seen, parallel_seen);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
